[hdl/cllm_pkg.sv]
// ============================================================================
// cllm_pkg
// Shared widths, codes and controller/datapath interface types for the
// cursor linked list manager.
// ============================================================================
package cllm_pkg;

    localparam int POOL_SIZE_DEF = 64;

    localparam int LINK_W = 7;
    localparam int SLOT_W = 6;
    localparam int CH_W   = 8;
    localparam int POS_W  = 7;
    localparam int ST_W   = 3;
    localparam int CMD_W  = 2;

    // null link: all ones
    localparam logic [LINK_W-1:0] NIL = '1;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_RANGE     = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_RD_CUR,
        OP_STEP,
        OP_RD_FREE,
        OP_TAKE_FREE,
        OP_INS_FRONT,
        OP_INS_NODE,
        OP_INS_LINK,
        OP_DEL_MID,
        OP_DEL_HEAD,
        OP_PUSH_FREE,
        OP_EMIT,
        OP_EMIT_DUMP
    } dp_op_t;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_NODE,
        SEL_CUR
    } slot_sel_t;

    typedef struct packed {
        dp_op_t            op;
        logic [ST_W-1:0]   status;
        slot_sel_t         sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              pos_zero;
        logic              cur_ok;
        logic              free_ok;
        logic              prev_ok;
        logic              walk_more;
        logic              at_pos;
        logic              cnt_lt_pool;
        logic              dump_last;
        logic              match;
        logic              out_free;
    } dp_stat_t;

endpackage

[hdl/cllm_ram.sv]
// ============================================================================
// cllm_ram
// Generic single write port, single read port RAM with registered read data.
// Read data holds while no read is issued.
// ============================================================================
module cllm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/cllm_dp.sv]
// ============================================================================
// cllm_dp
// Datapath: link and character RAMs, list/free heads, walk registers and the
// output register. Executes one micro-op per cycle from the controller.
// ============================================================================
module cllm_dp #(
    parameter int POOL_SIZE = cllm_pkg::POOL_SIZE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cllm_pkg::dp_cmd_t              cmd,
    output cllm_pkg::dp_stat_t             stat,
    input  logic [cllm_pkg::CMD_W-1:0]     in_cmd,
    input  logic [cllm_pkg::CH_W-1:0]      in_ch,
    input  logic [cllm_pkg::POS_W-1:0]     in_pos,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cllm_pkg::ST_W-1:0]      out_status,
    output logic [cllm_pkg::CH_W-1:0]      out_ch,
    output logic [cllm_pkg::SLOT_W-1:0]    out_slot,
    output logic                           out_last
);

    import cllm_pkg::*;

    localparam int AW = $clog2(POOL_SIZE);
    localparam logic [LINK_W-1:0] POOL_L = LINK_W'(POOL_SIZE);
    localparam logic [LINK_W-1:0] LAST_K = LINK_W'(POOL_SIZE - 1);

    // link value of a slot that was never written since reset
    function automatic logic [LINK_W-1:0] rst_link(input logic [AW-1:0] a);
        logic [LINK_W-1:0] r;
        if (a == AW'(POOL_SIZE - 1))
        begin
            r = NIL;
        end
        else
        begin
            r = LINK_W'(a) + LINK_W'(1);
        end
        return r;
    endfunction

    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [CH_W-1:0]      ch_reg, ch_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [LINK_W-1:0]    cur_reg, cur_next;
    logic [LINK_W-1:0]    prev_reg, prev_next;
    logic [LINK_W-1:0]    cnt_reg, cnt_next;
    logic [LINK_W-1:0]    node_reg, node_next;
    logic [LINK_W-1:0]    free_head_reg, free_head_next;
    logic [LINK_W-1:0]    list_head_reg, list_head_next;
    logic [POOL_SIZE-1:0] written_reg, written_next;
    logic [AW-1:0]        rd_addr_reg, rd_addr_next;
    logic                 fresh_reg, fresh_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ST_W-1:0]      out_status_reg, out_status_next;
    logic [CH_W-1:0]      out_ch_reg, out_ch_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic                 out_last_reg, out_last_next;

    logic                 link_we;
    logic [AW-1:0]        link_waddr;
    logic [LINK_W-1:0]    link_wdata;
    logic                 link_re;
    logic [AW-1:0]        link_raddr;
    logic [LINK_W-1:0]    link_q;
    logic                 char_we;
    logic [CH_W-1:0]      char_q;
    logic [LINK_W-1:0]    lq;
    logic                 lq_ok;
    logic                 dump_last;
    logic [SLOT_W-1:0]    slot_pick;

    cllm_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_SIZE)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_q)
    );

    cllm_ram #(
        .WIDTH (CH_W),
        .DEPTH (POOL_SIZE)
    ) u_char_ram (
        .clk   (clk),
        .we    (char_we),
        .waddr (node_reg[AW-1:0]),
        .wdata (ch_reg),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (char_q)
    );

    assign lq        = fresh_reg ? rst_link(rd_addr_reg) : link_q;
    assign lq_ok     = lq < POOL_L;
    assign dump_last = !lq_ok || (cnt_reg >= LAST_K);

    always_comb
    begin
        case (cmd.sel)
            SEL_NODE: slot_pick = SLOT_W'(node_reg[AW-1:0]);
            SEL_CUR:  slot_pick = SLOT_W'(cur_reg[AW-1:0]);
            default:  slot_pick = '0;
        endcase
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        ch_next         = ch_reg;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        cnt_next        = cnt_reg;
        node_next       = node_reg;
        free_head_next  = free_head_reg;
        list_head_next  = list_head_reg;
        written_next    = written_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        out_status_next = out_status_reg;
        out_ch_next     = out_ch_reg;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;
        link_we         = 1'b0;
        link_waddr      = cur_reg[AW-1:0];
        link_wdata      = lq;
        link_re         = 1'b0;
        link_raddr      = cur_reg[AW-1:0];
        char_we         = 1'b0;

        case (cmd.op)
            OP_LOAD:
            begin
                cmd_next  = in_cmd;
                ch_next   = in_ch;
                pos_next  = in_pos;
                cur_next  = list_head_reg;
                prev_next = NIL;
                cnt_next  = (in_cmd == CMD_INSERT) ? LINK_W'(1) : '0;
            end
            OP_RD_CUR:
            begin
                link_re = 1'b1;
            end
            OP_STEP:
            begin
                prev_next = cur_reg;
                cur_next  = lq;
                cnt_next  = cnt_reg + LINK_W'(1);
            end
            OP_RD_FREE:
            begin
                link_re    = 1'b1;
                link_raddr = free_head_reg[AW-1:0];
            end
            OP_TAKE_FREE:
            begin
                node_next      = free_head_reg;
                free_head_next = lq;
            end
            OP_INS_FRONT:
            begin
                link_we        = 1'b1;
                link_waddr     = node_reg[AW-1:0];
                link_wdata     = list_head_reg;
                char_we        = 1'b1;
                list_head_next = node_reg;
            end
            OP_INS_NODE:
            begin
                link_we    = 1'b1;
                link_waddr = node_reg[AW-1:0];
                char_we    = 1'b1;
            end
            OP_INS_LINK:
            begin
                link_we    = 1'b1;
                link_wdata = node_reg;
            end
            OP_DEL_MID:
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg[AW-1:0];
            end
            OP_DEL_HEAD:
            begin
                list_head_next = lq;
            end
            OP_PUSH_FREE:
            begin
                link_we        = 1'b1;
                link_wdata     = free_head_reg;
                free_head_next = cur_reg;
            end
            OP_EMIT:
            begin
                out_valid_next  = 1'b1;
                out_status_next = cmd.status;
                out_ch_next     = '0;
                out_slot_next   = slot_pick;
                out_last_next   = 1'b1;
            end
            OP_EMIT_DUMP:
            begin
                out_valid_next  = 1'b1;
                out_status_next = ST_OK;
                out_ch_next     = char_q;
                out_slot_next   = SLOT_W'(cur_reg[AW-1:0]);
                out_last_next   = dump_last;
                prev_next       = cur_reg;
                cur_next        = lq;
                cnt_next        = cnt_reg + LINK_W'(1);
            end
            default:
            begin
            end
        endcase

        if (link_we)
        begin
            written_next[link_waddr] = 1'b1;
        end
    end

    // reading a never-written link returns its reset value instead of RAM data
    assign rd_addr_next = link_re ? link_raddr : rd_addr_reg;
    assign fresh_next   = link_re ? !written_reg[link_raddr] : fresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            list_head_reg <= NIL;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            free_head_reg <= free_head_next;
            list_head_reg <= list_head_next;
            written_reg   <= written_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        ch_reg         <= ch_next;
        pos_reg        <= pos_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        cnt_reg        <= cnt_next;
        node_reg       <= node_next;
        rd_addr_reg    <= rd_addr_next;
        fresh_reg      <= fresh_next;
        out_status_reg <= out_status_next;
        out_ch_reg     <= out_ch_next;
        out_slot_reg   <= out_slot_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        stat.cmd         = cmd_reg;
        stat.pos_zero    = (pos_reg == '0);
        stat.cur_ok      = cur_reg < POOL_L;
        stat.free_ok     = free_head_reg < POOL_L;
        stat.prev_ok     = prev_reg < POOL_L;
        stat.walk_more   = (cnt_reg < LINK_W'(pos_reg)) && (cnt_reg <= POOL_L);
        stat.at_pos      = (cnt_reg == LINK_W'(pos_reg));
        stat.cnt_lt_pool = cnt_reg < POOL_L;
        stat.dump_last   = dump_last;
        stat.match       = (char_q == ch_reg);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_ch     = out_ch_reg;
    assign out_slot   = out_slot_reg;
    assign out_last   = out_last_reg;

endmodule

[hdl/cllm_ctrl.sv]
// ============================================================================
// cllm_ctrl
// Controller: sequences insert, delete and dump as micro-ops on the datapath.
// ============================================================================
module cllm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cllm_pkg::dp_stat_t    stat,
    output cllm_pkg::dp_cmd_t     cmd
);

    import cllm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_I_WALK,
        S_I_WAIT,
        S_I_FREE,
        S_I_FREE_W,
        S_I_FRONT,
        S_I_RD_PREV,
        S_I_PREV_W,
        S_I_LINK,
        S_D_LOOP,
        S_D_CHK,
        S_D_FREE,
        S_P_LOOP,
        S_P_OUT,
        S_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [ST_W-1:0] st_reg, st_next;
    slot_sel_t       sel_reg, sel_next;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        sel_next   = sel_reg;
        cmd.op     = OP_IDLE;
        cmd.status = st_reg;
        cmd.sel    = sel_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.cmd)
                    CMD_INSERT:
                    begin
                        state_next = S_I_WALK;
                    end
                    CMD_DELETE:
                    begin
                        if (stat.cur_ok)
                        begin
                            state_next = S_D_LOOP;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                            st_next    = ST_EMPTY;
                            sel_next   = SEL_ZERO;
                        end
                    end
                    CMD_DUMP:
                    begin
                        if (stat.cur_ok)
                        begin
                            state_next = S_P_LOOP;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                            st_next    = ST_EMPTY;
                            sel_next   = SEL_ZERO;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_I_WALK:
            begin
                if (stat.pos_zero)
                begin
                    state_next = S_I_FREE;
                end
                else if (stat.cur_ok && stat.walk_more)
                begin
                    cmd.op     = OP_RD_CUR;
                    state_next = S_I_WAIT;
                end
                else if (!stat.cur_ok || !stat.at_pos)
                begin
                    state_next = S_EMIT;
                    st_next    = ST_RANGE;
                    sel_next   = SEL_ZERO;
                end
                else
                begin
                    state_next = S_I_FREE;
                end
            end
            S_I_WAIT:
            begin
                cmd.op     = OP_STEP;
                state_next = S_I_WALK;
            end
            S_I_FREE:
            begin
                if (!stat.free_ok)
                begin
                    state_next = S_EMIT;
                    st_next    = ST_FULL;
                    sel_next   = SEL_ZERO;
                end
                else
                begin
                    cmd.op     = OP_RD_FREE;
                    state_next = S_I_FREE_W;
                end
            end
            S_I_FREE_W:
            begin
                cmd.op     = OP_TAKE_FREE;
                state_next = stat.pos_zero ? S_I_FRONT : S_I_RD_PREV;
            end
            S_I_FRONT:
            begin
                cmd.op     = OP_INS_FRONT;
                state_next = S_EMIT;
                st_next    = ST_OK;
                sel_next   = SEL_NODE;
            end
            S_I_RD_PREV:
            begin
                cmd.op     = OP_RD_CUR;
                state_next = S_I_PREV_W;
            end
            S_I_PREV_W:
            begin
                cmd.op     = OP_INS_NODE;
                state_next = S_I_LINK;
            end
            S_I_LINK:
            begin
                cmd.op     = OP_INS_LINK;
                state_next = S_EMIT;
                st_next    = ST_OK;
                sel_next   = SEL_NODE;
            end
            S_D_LOOP:
            begin
                if (stat.cur_ok && stat.cnt_lt_pool)
                begin
                    cmd.op     = OP_RD_CUR;
                    state_next = S_D_CHK;
                end
                else
                begin
                    state_next = S_EMIT;
                    st_next    = ST_NOT_FOUND;
                    sel_next   = SEL_ZERO;
                end
            end
            S_D_CHK:
            begin
                if (stat.match)
                begin
                    cmd.op     = stat.prev_ok ? OP_DEL_MID : OP_DEL_HEAD;
                    state_next = S_D_FREE;
                end
                else
                begin
                    cmd.op     = OP_STEP;
                    state_next = S_D_LOOP;
                end
            end
            S_D_FREE:
            begin
                cmd.op     = OP_PUSH_FREE;
                state_next = S_EMIT;
                st_next    = ST_OK;
                sel_next   = SEL_CUR;
            end
            S_P_LOOP:
            begin
                cmd.op     = OP_RD_CUR;
                state_next = S_P_OUT;
            end
            S_P_OUT:
            begin
                // RAM read data holds while the output register is full
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT_DUMP;
                    state_next = stat.dump_last ? S_IDLE : S_P_LOOP;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
            sel_reg   <= SEL_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            sel_reg   <= sel_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

[hdl/cursor_linked_list_manager_top.sv]
// ============================================================================
// cursor_linked_list_manager_top
// Pool of nodes kept as a character list and a free list of next links;
// insert, delete-first-match and dump commands with status reporting.
// ============================================================================
//  channel   dir  signals                   beat contents
//  s_*       in   tvalid tready tuser tdata  tuser: cmd; tdata: ch, position
//  m_*       out  tvalid tready tuser tdata  tuser: status; tdata: ch_out, slot;
//                 tlast                      tlast: last
//
//  One command at a time; s_tready is high only while idle.
//  Each list element walked takes a link RAM read state and a following state:
//  the registered link RAM read feeds the next address.
//  No clearing pass after reset: per-slot written bits give the reset links.
//  m_tready low stalls the walk at the output register.
// ============================================================================
module cursor_linked_list_manager_top #(
    parameter int POOL_SIZE = cllm_pkg::POOL_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,    // [1:0] cmd
    input  logic [15:0] s_tdata,    // [7:0] ch, [14:8] position, [15] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,    // [2:0] status
    output logic [15:0] m_tdata,    // [7:0] ch_out, [13:8] slot, [15:14] zero
    output logic        m_tlast
);

    import cllm_pkg::*;

    dp_cmd_t             dp_cmd;
    dp_stat_t            dp_stat;
    logic [CH_W-1:0]     out_ch;
    logic [SLOT_W-1:0]   out_slot;

    cllm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    cllm_dp #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .in_cmd     (s_tuser),
        .in_ch      (s_tdata[7:0]),
        .in_pos     (s_tdata[14:8]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_ch     (out_ch),
        .out_slot   (out_slot),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, out_slot, out_ch};

    // a command is still busy in the cycle after its beat is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // results are only written into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.op == OP_EMIT || dp_cmd.op == OP_EMIT_DUMP) |-> dp_stat.out_free)
        else $error("output register overwritten");

    // back in idle only after the final result of the command
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && s_tready |-> m_tlast)
        else $error("idle with a non-final result pending");

endmodule

[bench/tb.sv]
// ============================================================================
// tb
// Self-checking bench for the cursor linked list manager: a queue-fed stream
// driver, a predictor of the node pool and both chains, and a beat monitor
// that checks every result beat against the oldest expected one. Both sides
// idle in random bursts; the tail of the run has none.
// ============================================================================
module tb;
    import cllm_pkg::*;

    localparam int POOL_SIZE = POOL_SIZE_DEF;
    localparam int N_RANDOM = 340;
    localparam int N_CALM = 40;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 2 * POOL_SIZE + 20;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [CH_W-1:0]  ch;
        logic [POS_W-1:0] position;
    } list_cmd_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [CH_W-1:0]   ch_out;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } result_beat_t;

    typedef enum logic { GROW, SHRINK } trend_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;      // [1:0] cmd
    logic [15:0] s_tdata = '0;      // [7:0] ch, [14:8] position, [15] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [2:0]  m_tuser;           // [2:0] status
    logic [15:0] m_tdata;           // [7:0] ch_out, [13:8] slot, [15:14] zero
    logic        m_tlast;

    // predicted pool
    logic [LINK_W-1:0] next_link [POOL_SIZE];
    logic [CH_W-1:0]   node_char [POOL_SIZE];
    logic [LINK_W-1:0] free_top;
    logic [LINK_W-1:0] chain_head;

    list_cmd_t    cmd_queue [$];
    result_beat_t expected_beats [$];
    list_cmd_t    on_bus;

    int  errors = 0;
    int  beat_no = 0;
    int  cycles = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  calm = 1'b0;

    cursor_linked_list_manager_top #(
        .POOL_SIZE(POOL_SIZE)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit in_pool(logic [LINK_W-1:0] idx);
        return idx < POOL_SIZE;
    endfunction

    function automatic void add_beat(logic [ST_W-1:0] status, logic [CH_W-1:0] ch_out,
                                     logic [LINK_W-1:0] slot, logic last);
        result_beat_t b;
        b.status = status;
        b.ch_out = ch_out;
        b.slot = slot[SLOT_W-1:0];
        b.last = last;
        expected_beats.push_back(b);
    endfunction

    // Advance the predicted pool by one command and queue the beats it yields.
    function automatic void apply_command(list_cmd_t c);
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] node;
        logic [LINK_W-1:0] nxt;
        int i;
        bit found;
        prev = NIL;
        found = 1'b0;
        case (c.cmd)
            CMD_INSERT:
            begin
                if (c.position != 0)
                begin
                    cur = chain_head;
                    i = 1;
                    while (in_pool(cur) && i < c.position && i <= POOL_SIZE)
                    begin
                        cur = next_link[cur];
                        i++;
                    end
                    if (!in_pool(cur) || i != c.position)
                    begin
                        add_beat(ST_RANGE, '0, '0, 1'b1);
                        return;
                    end
                    prev = cur;
                end
                node = free_top;
                if (!in_pool(node))
                begin
                    add_beat(ST_FULL, '0, '0, 1'b1);
                    return;
                end
                free_top = next_link[node];
                if (c.position == 0)
                begin
                    next_link[node] = chain_head;
                    chain_head = node;
                end
                else
                begin
                    next_link[node] = next_link[prev];
                    next_link[prev] = node;
                end
                node_char[node] = c.ch;
                add_beat(ST_OK, '0, node, 1'b1);
            end
            CMD_DELETE:
            begin
                cur = chain_head;
                if (!in_pool(cur))
                begin
                    add_beat(ST_EMPTY, '0, '0, 1'b1);
                    return;
                end
                i = 0;
                while (in_pool(cur) && i < POOL_SIZE && !found)
                begin
                    if (node_char[cur] == c.ch)
                    begin
                        if (in_pool(prev))
                            next_link[prev] = next_link[cur];
                        else
                            chain_head = next_link[cur];
                        next_link[cur] = free_top;
                        free_top = cur;
                        add_beat(ST_OK, '0, cur, 1'b1);
                        found = 1'b1;
                    end
                    else
                    begin
                        prev = cur;
                        cur = next_link[cur];
                        i++;
                    end
                end
                if (!found)
                    add_beat(ST_NOT_FOUND, '0, '0, 1'b1);
            end
            CMD_DUMP:
            begin
                cur = chain_head;
                if (!in_pool(cur))
                begin
                    add_beat(ST_EMPTY, '0, '0, 1'b1);
                    return;
                end
                i = 0;
                while (in_pool(cur) && i < POOL_SIZE)
                begin
                    nxt = next_link[cur];
                    add_beat(ST_OK, node_char[cur], cur, !in_pool(nxt) || i + 1 >= POOL_SIZE);
                    cur = nxt;
                    i++;
                end
            end
            default:
            begin
                // unused code: no beats, no state change
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch at beat %0d: %s got %0h want %0h", beat_no, what, got, want);
    endtask

    task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch,
                             logic [POS_W-1:0] position);
        list_cmd_t c;
        while (cmd_queue.size() >= 2)
            @(negedge clk);
        c.cmd = cmd;
        c.ch = ch;
        c.position = position;
        cmd_queue.push_back(c);
    endtask

    // cycle count, timeout and idle-rate epochs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("cursor_linked_list_manager_top verification failed");
            $finish;
        end
        if (cycles % 300 == 0)
        begin
            case ($urandom_range(0, 2))
                0: tx_idle_pct <= 0;
                1: tx_idle_pct <= 8;
                default: tx_idle_pct <= 30;
            endcase
            case ($urandom_range(0, 2))
                0: rx_idle_pct <= 0;
                1: rx_idle_pct <= 8;
                default: rx_idle_pct <= 30;
            endcase
        end
    end

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tuser <= '0;
            s_tdata <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_command(on_bus);
            if (s_tvalid && !s_tready)
            begin
                // hold the beat
            end
            else if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (cmd_queue.size() != 0)
            begin
                on_bus = cmd_queue.pop_front();
                s_tuser <= on_bus.cmd;
                s_tdata <= {1'b0, on_bus.position, on_bus.ch};
                s_tvalid <= 1'b1;
                if (!calm && $urandom_range(0, 99) < tx_idle_pct)
                    gap_left <= $urandom_range(1, 14);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_beat_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_beats.size() == 0)
                    report_mismatch("unexpected beat, status", m_tuser, 0);
                else
                begin
                    want = expected_beats.pop_front();
                    if (m_tuser != want.status)
                        report_mismatch("status", m_tuser, want.status);
                    if (m_tdata[7:0] != want.ch_out)
                        report_mismatch("ch_out", m_tdata[7:0], want.ch_out);
                    if (m_tdata[13:8] != want.slot)
                        report_mismatch("slot", m_tdata[13:8], want.slot);
                    if (m_tdata[15:14] != 2'b00)
                        report_mismatch("tdata pad", m_tdata[15:14], 0);
                    if (m_tlast != want.last)
                        report_mismatch("last", m_tlast, want.last);
                end
                beat_no <= beat_no + 1;
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < rx_idle_pct)
            begin
                stall_left <= $urandom_range(0, 13);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        logic [CH_W-1:0]   chars [$];
        logic [CH_W-1:0]   pick_set [4];
        logic [LINK_W-1:0] cur;
        logic [CH_W-1:0]   ch;
        logic [POS_W-1:0]  pos;
        trend_t trend;
        int n;
        int len;
        int r;

        pick_set[0] = 8'h00;
        pick_set[1] = 8'h5A;
        pick_set[2] = 8'hA5;
        pick_set[3] = 8'hFF;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            next_link[i] = (i == POOL_SIZE - 1) ? NIL : LINK_W'(i + 1);
            node_char[i] = '0;
        end
        free_top = '0;
        chain_head = NIL;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty list, range checks, front/middle/tail edits, duplicates
        queue_cmd(CMD_DUMP, 8'h00, 7'd0);
        queue_cmd(CMD_DELETE, 8'h41, 7'd0);
        queue_cmd(CMD_INSERT, 8'h41, 7'd1);
        queue_cmd(CMD_INSERT, 8'h00, 7'd0);
        queue_cmd(CMD_INSERT, 8'hFF, 7'd1);
        queue_cmd(CMD_INSERT, 8'h55, 7'd2);
        queue_cmd(CMD_INSERT, 8'hAA, 7'd1);
        queue_cmd(CMD_INSERT, 8'h11, 7'd0);
        queue_cmd(CMD_INSERT, 8'h11, 7'd5);
        queue_cmd(CMD_INSERT, 8'h22, 7'd7);
        queue_cmd(CMD_INSERT, 8'h22, 7'd64);
        queue_cmd(CMD_INSERT, 8'h7F, 7'd6);
        queue_cmd(CMD_DUMP, 8'h00, 7'd0);
        queue_cmd(CMD_DELETE, 8'h99, 7'd0);
        queue_cmd(CMD_DELETE, 8'h11, 7'd0);
        queue_cmd(CMD_DELETE, 8'h7F, 7'd0);
        queue_cmd(CMD_DELETE, 8'hAA, 7'd0);
        queue_cmd(CMD_UNUSED, 8'hFF, 7'h7F);
        queue_cmd(CMD_DUMP, 8'h00, 7'd0);
        queue_cmd(CMD_DELETE, 8'h11, 7'd0);
        queue_cmd(CMD_DELETE, 8'h00, 7'd0);
        queue_cmd(CMD_DELETE, 8'hFF, 7'd0);
        queue_cmd(CMD_DELETE, 8'h55, 7'd0);
        queue_cmd(CMD_DUMP, 8'h00, 7'd0);

        // random: swing the list between empty and a full pool
        trend = GROW;
        n = 0;
        while (n < N_RANDOM)
        begin
            if (n >= N_RANDOM - N_CALM)
                calm = 1'b1;
            // snapshot of the list as predicted so far (may lag the commands still queued or on the bus)
            chars.delete();
            cur = chain_head;
            while (in_pool(cur) && chars.size() < POOL_SIZE)
            begin
                chars.push_back(node_char[cur]);
                cur = next_link[cur];
            end
            len = chars.size();
            if (trend == GROW && len == POOL_SIZE && $urandom_range(0, 3) == 0)
                trend = SHRINK;
            else if (trend == SHRINK && len == 0 && $urandom_range(0, 3) == 0)
                trend = GROW;
            else if ($urandom_range(0, 59) == 0)
                trend = (trend == GROW) ? SHRINK : GROW;

            r = $urandom_range(0, 99);
            if (r < ((trend == GROW) ? 72 : 20))
            begin
                ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : pick_set[$urandom_range(0, 3)];
                if (len < POOL_SIZE && $urandom_range(0, 9) == 0)
                    pos = POS_W'($urandom_range(len + 1, POOL_SIZE));
                else
                    pos = POS_W'($urandom_range(0, len));
                queue_cmd(CMD_INSERT, ch, pos);
                n++;
            end
            else if (r < 86)
            begin
                if (len > 0 && $urandom_range(0, 4) != 0)
                    ch = chars[$urandom_range(0, len - 1)];
                else
                    ch = 8'($urandom_range(0, 255));
                queue_cmd(CMD_DELETE, ch, POS_W'($urandom_range(0, 127)));
                n++;
            end
            else if (r < 97)
            begin
                queue_cmd(CMD_DUMP, 8'($urandom_range(0, 255)), POS_W'($urandom_range(0, 127)));
                n++;
            end
            else
                queue_cmd(CMD_UNUSED, 8'($urandom_range(0, 255)), POS_W'($urandom_range(0, 127)));
        end

        while (cmd_queue.size() != 0 || s_tvalid)
            @(negedge clk);
        while (expected_beats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("cursor_linked_list_manager_top verification clean");
        else
            $display("cursor_linked_list_manager_top verification failed");
        $finish;
    end

endmodule

[cursor_linked_list_manager_top.f]
hdl/cllm_pkg.sv
hdl/cllm_ram.sv
hdl/cllm_dp.sv
hdl/cllm_ctrl.sv
hdl/cursor_linked_list_manager_top.sv
bench/tb.sv
